// ===== design/wmb_pkg.sv =====
`default_nettype none
package wmb_pkg;

    // Channel and pixel geometry
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 4 * CHAN_W;
    localparam int PIX_MAX = 255;

    // Configuration port
    localparam int CFG_DW = 11;
    localparam int RAD_W  = 3;

    localparam logic [CFG_DW-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [CFG_DW-1:0] HEIGHT_RST = 11'd1024;
    localparam logic [RAD_W-1:0]  RADIUS_RST = 3'd1;
    localparam logic              MODE_RST   = 1'b0;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_WINDOW_RADIUS  = 2'd2,
        CFG_NORMALIZE_MODE = 2'd3
    } t_cfg_idx;

    // Item kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Depth of the job queue between front and back
    localparam int JOB_QDEPTH = 4;

    // Back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WALK,
        BK_DRAIN,
        BK_LOAD,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage
`default_nettype wire

// ===== design/wmb_store.sv =====
`default_nettype none
// Simple dual-port pixel store, registered read
module wmb_store #(
    parameter int AW = 14,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/wmb_fifo.sv =====
`default_nettype none
// Small job queue between front and back
module wmb_fifo #(
    parameter int DW    = 32,
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_not_empty,
    output logic      [DW-1:0] o_data
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0]   r_mem [DEPTH];
    logic [PTRW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTRW:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full      = (r_count == (PTRW+1)'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd_ptr];

    // Pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTRW'(DEPTH - 1)) ? '0 : r_wr_ptr + PTRW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTRW'(DEPTH - 1)) ? '0 : r_rd_ptr + PTRW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + (PTRW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (PTRW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/wmb_front.sv =====
`default_nettype none
// Front end: takes items, writes the pixel store, issues one job per due output
module wmb_front #(
    parameter int WW = 11,
    parameter int XW = 10,
    parameter int YW = 10,
    parameter int PW = 21,
    parameter int AW = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        i_action,
    input  wire logic [wmb_pkg::PIX_W-1:0]   i_pixel,
    output logic                             o_stall,
    input  wire logic                        i_restart,
    input  wire logic [WW-1:0]               i_w,
    input  wire logic [PW-1:0]               i_lag,
    input  wire logic [PW-1:0]               i_total,
    input  wire logic                        i_full,
    input  wire logic                        i_back_busy,
    output logic                             o_push,
    output logic      [1+YW+XW+AW-1:0]       o_job,
    output logic                             o_wr_en,
    output logic      [AW-1:0]               o_wr_addr,
    output logic      [wmb_pkg::PIX_W-1:0]   o_wr_data
);

    logic [PW-1:0] r_in_pos, n_in_pos;
    logic [PW-1:0] r_out_pos, n_out_pos;
    logic [YW-1:0] r_out_row, n_out_row;
    logic [XW-1:0] r_out_col, n_out_col;
    logic [AW-1:0] r_gaddr, n_gaddr;
    logic          r_hold, n_hold;
    logic          accept, due, last, col_end;

    // New frame waits until the back end has finished the previous one,
    // so its leading rows cannot overwrite store entries still to be read
    assign o_stall = i_full || r_hold;
    assign accept  = i_valid && !o_stall;
    assign due     = (r_in_pos >= i_lag);
    assign last    = (({1'b0, r_out_pos} + (PW+1)'(1)) >= {1'b0, i_total});
    assign col_end = ((WW'(r_out_col) + WW'(1)) == i_w);

    // Store write: only positions inside the frame keep data
    assign o_wr_en   = accept && (r_in_pos < i_total);
    assign o_wr_addr = r_gaddr;
    assign o_wr_data = (i_action == wmb_pkg::ACT_FLUSH) ? '0 : i_pixel;

    // Job: end-of-frame flag, output coordinates, store address of the center
    assign o_push = accept && due;
    assign o_job  = {last, r_out_row, r_out_col, r_gaddr - i_lag[AW-1:0]};

    // Frame boundary hold
    always_comb begin
        n_hold = r_hold;
        if (i_restart) begin
            n_hold = 1'b0;
        end else if (accept && due && last) begin
            n_hold = 1'b1;
        end else if (!i_back_busy) begin
            n_hold = 1'b0;
        end
    end

    // Position counters
    always_comb begin
        n_in_pos  = r_in_pos;
        n_out_pos = r_out_pos;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_gaddr   = r_gaddr;
        if (i_restart) begin
            n_in_pos  = '0;
            n_out_pos = '0;
            n_out_row = '0;
            n_out_col = '0;
        end else if (accept) begin
            n_gaddr = r_gaddr + AW'(1);
            if (due && last) begin
                n_in_pos  = '0;
                n_out_pos = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else begin
                n_in_pos = r_in_pos + PW'(1);
                if (due) begin
                    n_out_pos = r_out_pos + PW'(1);
                    if (col_end) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + YW'(1);
                    end else begin
                        n_out_col = r_out_col + XW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pos  <= '0;
            r_out_pos <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_gaddr   <= '0;
            r_hold    <= 1'b0;
        end else begin
            r_in_pos  <= n_in_pos;
            r_out_pos <= n_out_pos;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_gaddr   <= n_gaddr;
            r_hold    <= n_hold;
        end
    end

endmodule
`default_nettype wire

// ===== design/wmb_div.sv =====
`default_nettype none
// Three-lane restoring divider, one quotient bit per cycle, shared divisor
module wmb_div #(
    parameter int SW = 16,
    parameter int NW = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [SW-1:0]                i_dividend [3],
    input  wire logic [NW-1:0]                i_divisor,
    output logic                              o_busy,
    output logic      [wmb_pkg::CHAN_W-1:0]   o_quot [3]
);

    localparam int SCW = $clog2(SW);

    logic           r_busy;
    logic [SCW-1:0] r_step;
    logic [SW-1:0]  r_q [3];
    logic [NW-1:0]  r_rem [3];
    logic [NW-1:0]  r_div;
    logic [SW-1:0]  n_q [3];
    logic [NW-1:0]  n_rem [3];
    logic [NW:0]    trial [3];

    // One shift-subtract step per lane
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            trial[i] = {r_rem[i], r_q[i][SW-1]};
            if (trial[i] >= {1'b0, r_div}) begin
                n_rem[i] = NW'(trial[i] - {1'b0, r_div});
                n_q[i]   = {r_q[i][SW-2:0], 1'b1};
            end else begin
                n_rem[i] = trial[i][NW-1:0];
                n_q[i]   = {r_q[i][SW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + SCW'(1);
            if (r_step == SCW'(SW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            for (int i = 0; i < 3; i++) begin
                r_q[i]   <= i_dividend[i];
                r_rem[i] <= '0;
            end
        end else if (r_busy) begin
            for (int i = 0; i < 3; i++) begin
                r_q[i]   <= n_q[i];
                r_rem[i] <= n_rem[i];
            end
        end
    end

    assign o_busy = r_busy;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_quot[i] = r_q[i][wmb_pkg::CHAN_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== design/wmb_back.sv =====
`default_nettype none
// Back end: walks the window of one job through the store, sums, divides, presents
module wmb_back #(
    parameter int WW = 11,
    parameter int HW = 11,
    parameter int XW = 10,
    parameter int YW = 10,
    parameter int AW = 14,
    parameter int RW = 3,
    parameter int NW = 8,
    parameter int SW = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_job_valid,
    input  wire logic [1+YW+XW+AW-1:0]       i_job,
    output logic                             o_pop,
    output logic                             o_busy,
    input  wire logic [WW-1:0]               i_w,
    input  wire logic [HW-1:0]               i_h,
    input  wire logic [RW-1:0]               i_r,
    input  wire logic [AW-1:0]               i_lag,
    input  wire logic                        i_mode,
    output logic                             o_rd_en,
    output logic      [AW-1:0]               o_rd_addr,
    input  wire logic [wmb_pkg::PIX_W-1:0]   i_rd_data,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [wmb_pkg::CHAN_W-1:0]  o_red,
    output logic      [wmb_pkg::CHAN_W-1:0]  o_green,
    output logic      [wmb_pkg::CHAN_W-1:0]  o_blue,
    output logic      [wmb_pkg::CHAN_W-1:0]  o_alpha,
    output logic                             o_frame_end
);

    localparam int CW = ((XW > YW) ? XW : YW) + 2;
    localparam int CH = wmb_pkg::CHAN_W;

    wmb_pkg::t_back_state r_state, n_state;

    logic [AW-1:0]        r_addr, r_row_addr, n_row_addr;
    logic [RW:0]          r_dy, r_dx;
    logic signed [CW-1:0] r_y, r_x, r_x0;
    logic                 r_rd_v, r_rd_c;
    logic [SW-1:0]        r_sum [3];
    logic [NW-1:0]        r_cnt;
    logic [CH-1:0]        r_alpha;
    logic                 r_last;
    logic [CH-1:0]        r_out [3];

    logic [AW-1:0]        job_addr;
    logic [XW-1:0]        job_col;
    logic [YW-1:0]        job_row;
    logic                 job_last;
    logic [RW:0]          two_r, side;
    logic [NW-1:0]        area, divisor;
    logic                 in_frame, center, row_end, walk_end;
    logic                 div_start, div_busy;
    logic [CH-1:0]        quot [3];

    assign job_addr = i_job[AW-1:0];
    assign job_col  = i_job[AW +: XW];
    assign job_row  = i_job[AW+XW +: YW];
    assign job_last = i_job[AW+XW+YW];

    assign two_r   = {i_r, 1'b0};
    assign side    = {i_r, 1'b1};
    assign area    = NW'(side) * NW'(side);
    assign divisor = i_mode ? r_cnt : area;

    assign in_frame = !r_y[CW-1] && (r_y < $signed(CW'(i_h)))
                   && !r_x[CW-1] && (r_x < $signed(CW'(i_w)));
    assign center   = (r_dy == {1'b0, i_r}) && (r_dx == {1'b0, i_r});
    assign row_end  = (r_dx == two_r);
    assign walk_end = row_end && (r_dy == two_r);
    assign n_row_addr = r_row_addr + AW'(i_w);

    assign o_busy = (r_state != wmb_pkg::BK_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wmb_pkg::BK_IDLE:  if (i_job_valid) n_state = wmb_pkg::BK_WALK;
            wmb_pkg::BK_WALK:  if (walk_end) n_state = wmb_pkg::BK_DRAIN;
            wmb_pkg::BK_DRAIN: n_state = wmb_pkg::BK_LOAD;
            wmb_pkg::BK_LOAD:  n_state = wmb_pkg::BK_DIV;
            wmb_pkg::BK_DIV:   if (!div_busy) n_state = wmb_pkg::BK_OUT;
            wmb_pkg::BK_OUT:   if (!i_stall) n_state = wmb_pkg::BK_IDLE;
            default:           n_state = wmb_pkg::BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop     = 1'b0;
        o_rd_en   = 1'b0;
        div_start = 1'b0;
        o_valid   = 1'b0;
        case (r_state)
            wmb_pkg::BK_IDLE: o_pop     = i_job_valid;
            wmb_pkg::BK_WALK: o_rd_en   = in_frame;
            wmb_pkg::BK_LOAD: div_start = 1'b1;
            wmb_pkg::BK_OUT:  o_valid   = 1'b1;
            default:          o_pop     = 1'b0;
        endcase
    end

    assign o_rd_addr = r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmb_pkg::BK_IDLE;
            r_rd_v  <= 1'b0;
            r_rd_c  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= o_rd_en;
            r_rd_c  <= o_rd_en && center;
        end
    end

    // Window walk, accumulation and result capture
    always_ff @(posedge i_clk) begin
        case (r_state)
            wmb_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    r_addr     <= job_addr - i_lag;
                    r_row_addr <= job_addr - i_lag;
                    r_dy       <= '0;
                    r_dx       <= '0;
                    r_y        <= $signed(CW'(job_row)) - $signed(CW'(i_r));
                    r_x        <= $signed(CW'(job_col)) - $signed(CW'(i_r));
                    r_x0       <= $signed(CW'(job_col)) - $signed(CW'(i_r));
                    r_last     <= job_last;
                    r_cnt      <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_sum[i] <= '0;
                    end
                end
            end
            wmb_pkg::BK_WALK: begin
                if (row_end) begin
                    r_dx       <= '0;
                    r_dy       <= r_dy + (RW+1)'(1);
                    r_x        <= r_x0;
                    r_y        <= r_y + CW'(1);
                    r_row_addr <= n_row_addr;
                    r_addr     <= n_row_addr;
                end else begin
                    r_dx   <= r_dx + (RW+1)'(1);
                    r_x    <= r_x + CW'(1);
                    r_addr <= r_addr + AW'(1);
                end
            end
            wmb_pkg::BK_DIV: begin
                if (!div_busy) begin
                    for (int i = 0; i < 3; i++) begin
                        r_out[i] <= quot[i];
                    end
                end
            end
            default: begin
            end
        endcase
        // read data arrives in the cycle after the address
        if (r_rd_v) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= r_sum[i] + SW'(i_rd_data[CH*i +: CH]);
            end
            r_cnt <= r_cnt + NW'(1);
            if (r_rd_c) begin
                r_alpha <= i_rd_data[3*CH +: CH];
            end
        end
    end

    wmb_div #(
        .SW(SW),
        .NW(NW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_sum),
        .i_divisor (divisor),
        .o_busy    (div_busy),
        .o_quot    (quot)
    );

    assign o_red       = r_out[0];
    assign o_green     = r_out[1];
    assign o_blue      = r_out[2];
    assign o_alpha     = r_alpha;
    assign o_frame_end = r_last;

endmodule
`default_nettype wire

// ===== design/window_mean_blur_rgba.sv =====
`default_nettype none
// Streaming square-window mean filter for RGBA pixels in raster order. Each output
// is the truncated mean of red, green and blue over a (2r+1)x(2r+1) window; mode 0
// divides by the full window area, mode 1 by the in-frame pixel count; alpha is the
// center pixel's. Output k of a frame is released by input item k + r*width + r, and
// flush items push out the tail. Input transfers run one per cycle until the
// four-entry job queue fills; the back end then walks the window through the single
// read port of the pixel store, runs the 16-bit shift-subtract divide and hands off
// (take job, drain read, load divider, present); it finishes each output, held in
// the present step by any output stall, before it takes the next job. The first
// input of a new frame is held until the back end has finished every output of the
// previous frame.
// Writing any configuration register restarts the frame; write only while idle.
module window_mean_blur_rgba #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_action,
    input  wire logic [wmb_pkg::CHAN_W-1:0]     i_in_red,
    input  wire logic [wmb_pkg::CHAN_W-1:0]     i_in_green,
    input  wire logic [wmb_pkg::CHAN_W-1:0]     i_in_blue,
    input  wire logic [wmb_pkg::CHAN_W-1:0]     i_in_alpha,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic      [wmb_pkg::CHAN_W-1:0]     o_out_red,
    output logic      [wmb_pkg::CHAN_W-1:0]     o_out_green,
    output logic      [wmb_pkg::CHAN_W-1:0]     o_out_blue,
    output logic      [wmb_pkg::CHAN_W-1:0]     o_out_alpha,
    output logic                                o_frame_end,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [wmb_pkg::CFG_DW-1:0]     i_cfg_data
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                 + MAX_RADIUS + 1);
    localparam int AW   = $clog2(2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1
                                 + wmb_pkg::JOB_QDEPTH + 4);
    localparam int AREA = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int NW   = $clog2(AREA + 1);
    localparam int SW   = $clog2(AREA * wmb_pkg::PIX_MAX + 1);
    localparam int JW   = 1 + YW + XW + AW;

    logic [wmb_pkg::CFG_DW-1:0] r_frame_width, r_frame_height;
    logic [wmb_pkg::RAD_W-1:0]  r_window_radius;
    logic                       r_normalize_mode;

    logic [31:0]            w_full, h_full, r_full;
    logic [WW-1:0]          frame_w;
    logic [HW-1:0]          frame_h;
    logic [RW-1:0]          radius;
    logic [PW-1:0]          total, lag;

    logic                   fifo_full, fifo_push, fifo_pop, fifo_ne;
    logic                   back_active, back_busy;
    logic [JW-1:0]          job_in, job_out;
    logic                   wr_en, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [wmb_pkg::PIX_W-1:0] wr_data, rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= wmb_pkg::WIDTH_RST;
            r_frame_height   <= wmb_pkg::HEIGHT_RST;
            r_window_radius  <= wmb_pkg::RADIUS_RST;
            r_normalize_mode <= wmb_pkg::MODE_RST;
        end else if (i_cfg_we) begin
            case (wmb_pkg::t_cfg_idx'(i_cfg_index))
                wmb_pkg::CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data;
                wmb_pkg::CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data;
                wmb_pkg::CFG_WINDOW_RADIUS:  r_window_radius  <= i_cfg_data[wmb_pkg::RAD_W-1:0];
                wmb_pkg::CFG_NORMALIZE_MODE: r_normalize_mode <= i_cfg_data[0];
                default:                     r_normalize_mode <= r_normalize_mode;
            endcase
        end
    end

    // Clamp register values into the supported range
    always_comb begin
        if (r_frame_width == '0) begin
            w_full = 32'd1;
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end else begin
            w_full = 32'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_full = 32'd1;
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_full = 32'(MAX_HEIGHT);
        end else begin
            h_full = 32'(r_frame_height);
        end
        if (32'(r_window_radius) > 32'(MAX_RADIUS)) begin
            r_full = 32'(MAX_RADIUS);
        end else begin
            r_full = 32'(r_window_radius);
        end
    end

    assign frame_w = w_full[WW-1:0];
    assign frame_h = h_full[HW-1:0];
    assign radius  = r_full[RW-1:0];
    assign total   = PW'(frame_w) * PW'(frame_h);
    assign lag     = PW'(radius) * PW'(frame_w) + PW'(radius);

    // Back end still has work queued or in progress
    assign back_busy = fifo_ne || back_active;

    wmb_front #(
        .WW(WW), .XW(XW), .YW(YW), .PW(PW), .AW(AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_pixel     ({i_in_alpha, i_in_blue, i_in_green, i_in_red}),
        .o_stall     (o_stall),
        .i_restart   (i_cfg_we),
        .i_w         (frame_w),
        .i_lag       (lag),
        .i_total     (total),
        .i_full      (fifo_full),
        .i_back_busy (back_busy),
        .o_push      (fifo_push),
        .o_job       (job_in),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    wmb_fifo #(
        .DW(JW), .DEPTH(wmb_pkg::JOB_QDEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fifo_push),
        .i_data      (job_in),
        .o_full      (fifo_full),
        .i_pop       (fifo_pop),
        .o_not_empty (fifo_ne),
        .o_data      (job_out)
    );

    wmb_store #(
        .AW(AW), .DW(wmb_pkg::PIX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    wmb_back #(
        .WW(WW), .HW(HW), .XW(XW), .YW(YW), .AW(AW), .RW(RW), .NW(NW), .SW(SW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (fifo_ne),
        .i_job       (job_out),
        .o_pop       (fifo_pop),
        .o_busy      (back_active),
        .i_w         (frame_w),
        .i_h         (frame_h),
        .i_r         (radius),
        .i_lag       (lag[AW-1:0]),
        .i_mode      (r_normalize_mode),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_out_red),
        .o_green     (o_out_green),
        .o_blue      (o_out_blue),
        .o_alpha     (o_out_alpha),
        .o_frame_end (o_frame_end)
    );

endmodule
`default_nettype wire

// ===== design/wmb_checker.sv =====
`default_nettype none
// Port-level checks for the window mean filter
module wmb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_red,
    input wire logic [7:0] o_out_green,
    input wire logic [7:0] o_out_blue,
    input wire logic [7:0] o_out_alpha,
    input wire logic       o_frame_end
);

    // Reset leaves the output empty and the queue open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or input stall after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_red) && $stable(o_out_green)
            && $stable(o_out_blue) && $stable(o_out_alpha) && $stable(o_frame_end))
        else $error("stalled result changed");

    // Back end needs at least a walk and a divide between results
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_valid, 2))
        else $error("results too close together");

    // Result only leaves on a transfer
    a_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(!i_stall))
        else $error("result dropped without transfer");

endmodule

bind window_mean_blur_rgba wmb_checker u_wmb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue),
    .o_out_alpha (o_out_alpha),
    .o_frame_end (o_frame_end)
);
`default_nettype wire
